FILE: rtl/core/ehd_pkg.sv
// ehd_pkg: shared types, constants and calendar functions for the holiday date block
// holds the holiday codes, the computus pipeline record and the month table
// no dependencies
package ehd_pkg;

    typedef enum logic [2:0] {
        HOL_NEW_YEAR  = 3'd0,
        HOL_CARNIVAL  = 3'd1,
        HOL_GOOD_FRI  = 3'd2,
        HOL_EASTER    = 3'd3,
        HOL_ASCENSION = 3'd4,
        HOL_WHITSUN   = 3'd5
    } t_holiday;

    localparam logic [8:0] OFS_CARNIVAL  = 9'd47;
    localparam logic [8:0] OFS_GOOD_FRI  = 9'd2;
    localparam logic [8:0] OFS_ASCENSION = 9'd39;
    localparam logic [8:0] OFS_WHITSUN   = 9'd49;
    localparam logic [8:0] ORD_NEW_YEAR  = 9'd1;

    localparam int NUM_MONTHS = 12;
    localparam int NUM_STAGES = 10;

    localparam logic [8:0] DAYS_BEFORE [NUM_MONTHS] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // computus terms carried down the pipeline
    typedef struct packed {
        logic [13:0] year;
        logic [9:0]  q19;
        logic [7:0]  b;
        logic [4:0]  a;
        logic [6:0]  c;
        logic [5:0]  d;
        logic [1:0]  e;
        logic [3:0]  f;
        logic [4:0]  i;
        logic [1:0]  k;
        logic        leap;
        logic [5:0]  g;
        logic [9:0]  p;
        logic [9:0]  x;
        logic [4:0]  q30;
        logic [4:0]  h;
        logic [6:0]  w;
        logic [6:0]  z;
        logic [3:0]  q7;
        logic [2:0]  l;
        logic        m;
        logic [7:0]  s0;
        logic [8:0]  eo;
    } t_calc;

    function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        logic [8:0] base;
        idx  = month - 4'd1;
        base = (idx < 4'(NUM_MONTHS)) ? DAYS_BEFORE[idx] : 9'd0;
        return base + ((leap && month > 4'd2) ? 9'd1 : 9'd0);
    endfunction

    // latest month whose start lies before the ordinal day
    function automatic logic [3:0] month_of(input logic [8:0] ord, input logic leap);
        logic [3:0] mon;
        logic       found;
        mon   = 4'd1;
        found = 1'b0;
        for (int mm = NUM_MONTHS; mm >= 1; mm--) begin
            if (!found && month_start(4'(mm), leap) < ord) begin
                mon   = 4'(mm);
                found = 1'b1;
            end
        end
        return mon;
    endfunction

endpackage

FILE: rtl/core/easter_holiday_dates.sv
// easter_holiday_dates: Easter-based holiday dates for one Gregorian year
// ten-stage computus pipeline followed by a six-beat result sequencer
// depends on ehd_pkg
// results pass the sequencer, r_a_* and output registers, then come one beat per cycle
// years overlap in the pipeline, spaced by busy for the six beats on the one result port
// busy rises on each accept and stays high until the r_gap counter runs out
// reset: synchronous active-low, clears busy counter, pipeline valids, sequencer and strobe
// results cannot be stalled by the receiver
module easter_holiday_dates (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] i_year,
    output logic        o_valid,
    output logic [2:0]  o_holiday,
    output logic [3:0]  o_month_number,
    output logic [4:0]  o_day_of_month,
    output logic [8:0]  o_ordinal_day,
    output logic        o_last
);

    localparam int NSTG = ehd_pkg::NUM_STAGES;

    logic                   accept;
    logic [2:0]             r_gap;
    logic [2:0]             n_gap;
    logic [NSTG-1:0]        r_vld;
    ehd_pkg::t_calc         r_st [NSTG];
    ehd_pkg::t_calc         n_st [NSTG];

    logic                   r_act;
    logic                   n_act;
    ehd_pkg::t_holiday      r_cnt;
    ehd_pkg::t_holiday      n_cnt;
    logic [8:0]             r_eo;
    logic                   r_leap;

    logic                   r_a_vld;
    ehd_pkg::t_holiday      r_a_hol;
    logic [8:0]             r_a_ord;
    logic                   r_a_leap;
    logic [8:0]             n_a_ord;

    logic [3:0]             n_month;
    logic [8:0]             n_day;

    assign accept = start && !busy;
    assign busy   = (r_gap != 3'd0);

    always_comb begin
        n_gap = r_gap;
        if (accept) begin
            n_gap = 3'd5;
        end else if (r_gap != 3'd0) begin
            n_gap = r_gap - 3'd1;
        end
    end

    // computus pipeline
    always_comb begin
        logic [29:0] p19;
        logic [26:0] p100;
        logic [13:0] dif19;
        logic [13:0] dif100;
        logic [13:0] pf;
        logic [7:0]  gn;
        logic [15:0] pg;
        logic [9:0]  xv;
        logic [21:0] px;
        logic [9:0]  hv;
        logic [6:0]  zv;
        logic [14:0] pz;
        logic [6:0]  lv;
        logic [8:0]  num;
        logic [7:0]  sv;
        logic        april;
        logic [7:0]  dv;

        n_st[0]      = '0;
        n_st[0].year = i_year;

        // year split by 19 and 100
        n_st[1]      = r_st[0];
        p19          = 30'(r_st[0].year) * 30'd55189;
        p100         = 27'(r_st[0].year) * 27'd5243;
        n_st[1].q19  = p19[29:20];
        n_st[1].b    = p100[26:19];

        n_st[2]      = r_st[1];
        dif19        = r_st[1].year - 14'(r_st[1].q19) * 14'd19;
        dif100       = r_st[1].year - 14'(r_st[1].b) * 14'd100;
        n_st[2].a    = dif19[4:0];
        n_st[2].c    = dif100[6:0];
        n_st[2].d    = r_st[1].b[7:2];
        n_st[2].e    = r_st[1].b[1:0];
        pf           = 14'(r_st[1].b + 8'd8) * 14'd41;
        n_st[2].f    = pf[13:10];
        n_st[2].i    = dif100[6:2];
        n_st[2].k    = dif100[1:0];
        n_st[2].leap = (dif100[6:0] == 7'd0) ? (r_st[1].b[1:0] == 2'd0)
                                             : (r_st[1].year[1:0] == 2'd0);

        n_st[3]      = r_st[2];
        gn           = r_st[2].b - 8'(r_st[2].f) + 8'd1;
        pg           = 16'(gn) * 16'd171;
        n_st[3].g    = pg[14:9];
        n_st[3].p    = 10'(r_st[2].a) * 10'd19 + 10'(r_st[2].b) - 10'(r_st[2].d) + 10'd15;

        n_st[4]      = r_st[3];
        xv           = r_st[3].p - 10'(r_st[3].g);
        px           = 22'(xv) * 22'd2185;
        n_st[4].x    = xv;
        n_st[4].q30  = px[20:16];

        n_st[5]      = r_st[4];
        hv           = r_st[4].x - 10'(r_st[4].q30) * 10'd30;
        n_st[5].h    = hv[4:0];
        n_st[5].w    = 7'd32 + {4'b0, r_st[4].e, 1'b0} + {1'b0, r_st[4].i, 1'b0}
                       - 7'(r_st[4].k);

        n_st[6]      = r_st[5];
        zv           = r_st[5].w - 7'(r_st[5].h);
        pz           = 15'(zv) * 15'd147;
        n_st[6].z    = zv;
        n_st[6].q7   = pz[13:10];

        n_st[7]      = r_st[6];
        lv           = r_st[6].z - 7'(r_st[6].q7) * 7'd7;
        n_st[7].l    = lv[2:0];

        n_st[8]      = r_st[7];
        num          = 9'(r_st[7].a) + 9'(r_st[7].h) * 9'd11 + 9'(r_st[7].l) * 9'd22;
        n_st[8].m    = (num >= 9'd451);
        n_st[8].s0   = 8'(r_st[7].h) + 8'(r_st[7].l) + 8'd114;

        // easter month is march or april
        n_st[9]      = r_st[8];
        sv           = r_st[8].s0 - (r_st[8].m ? 8'd7 : 8'd0);
        april        = (sv >= 8'd124);
        dv           = sv - (april ? 8'd123 : 8'd92);
        n_st[9].eo   = ehd_pkg::month_start(april ? 4'd4 : 4'd3, r_st[8].leap) + 9'(dv);
    end

    // six-beat sequencer
    always_comb begin
        n_act = r_act;
        n_cnt = r_cnt;
        if (r_vld[NSTG-1]) begin
            n_act = 1'b1;
            n_cnt = ehd_pkg::HOL_NEW_YEAR;
        end else if (r_act) begin
            case (r_cnt)
                ehd_pkg::HOL_NEW_YEAR:  n_cnt = ehd_pkg::HOL_CARNIVAL;
                ehd_pkg::HOL_CARNIVAL:  n_cnt = ehd_pkg::HOL_GOOD_FRI;
                ehd_pkg::HOL_GOOD_FRI:  n_cnt = ehd_pkg::HOL_EASTER;
                ehd_pkg::HOL_EASTER:    n_cnt = ehd_pkg::HOL_ASCENSION;
                ehd_pkg::HOL_ASCENSION: n_cnt = ehd_pkg::HOL_WHITSUN;
                default: begin
                    n_act = 1'b0;
                    n_cnt = ehd_pkg::HOL_NEW_YEAR;
                end
            endcase
        end
    end

    always_comb begin
        case (r_cnt)
            ehd_pkg::HOL_NEW_YEAR:  n_a_ord = ehd_pkg::ORD_NEW_YEAR;
            ehd_pkg::HOL_CARNIVAL:  n_a_ord = r_eo - ehd_pkg::OFS_CARNIVAL;
            ehd_pkg::HOL_GOOD_FRI:  n_a_ord = r_eo - ehd_pkg::OFS_GOOD_FRI;
            ehd_pkg::HOL_ASCENSION: n_a_ord = r_eo + ehd_pkg::OFS_ASCENSION;
            ehd_pkg::HOL_WHITSUN:   n_a_ord = r_eo + ehd_pkg::OFS_WHITSUN;
            default:                n_a_ord = r_eo;
        endcase
    end

    always_comb begin
        n_month = ehd_pkg::month_of(r_a_ord, r_a_leap);
        n_day   = r_a_ord - ehd_pkg::month_start(n_month, r_a_leap);
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NSTG; s++) begin
            r_st[s] <= n_st[s];
        end
        if (r_vld[NSTG-1]) begin
            r_eo   <= r_st[NSTG-1].eo;
            r_leap <= r_st[NSTG-1].leap;
        end
        r_a_hol        <= r_cnt;
        r_a_ord        <= n_a_ord;
        r_a_leap       <= r_leap;
        o_holiday      <= r_a_hol;
        o_month_number <= n_month;
        o_day_of_month <= n_day[4:0];
        o_ordinal_day  <= r_a_ord;
        o_last         <= (r_a_hol == ehd_pkg::HOL_WHITSUN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= 3'd0;
            r_vld   <= '0;
            r_act   <= 1'b0;
            r_cnt   <= ehd_pkg::HOL_NEW_YEAR;
            r_a_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_gap   <= n_gap;
            r_vld   <= {r_vld[NSTG-2:0], accept};
            r_act   <= n_act;
            r_cnt   <= n_cnt;
            r_a_vld <= r_act;
            o_valid <= r_a_vld;
        end
    end

endmodule

FILE: tb/sv/ehd_checker.sv
// ehd_checker: predicts the six holiday dates for every year the block takes and
// compares each result beat field by field, in arrival order
// depends on ehd_pkg for the holiday codes and day offsets
module ehd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [13:0] i_year,
    input  logic        i_valid,
    input  logic [2:0]  i_holiday,
    input  logic [3:0]  i_month_number,
    input  logic [4:0]  i_day_of_month,
    input  logic [8:0]  i_ordinal_day,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_years,
    output int          o_beats
);

    localparam int HOLIDAYS_PER_YEAR = 6;

    typedef struct packed {
        ehd_pkg::t_holiday hol;
        logic [3:0]        mon;
        logic [4:0]        dom;
        logic [8:0]        ord;
        logic              last;
    } t_date_beat;

    t_date_beat date_queue [$];
    t_date_beat want;
    int         fail_count = 0;
    int         pending_count = 0;
    int         years_seen = 0;
    int         beats_seen = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_years      = years_seen;
    assign o_beats      = beats_seen;

    function automatic int month_length(input int mon, input bit leap);
        int lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (mon == 2 && leap)
            return 29;
        return lengths[mon - 1];
    endfunction

    function automatic int days_before_month(input int mon, input bit leap);
        int total;
        total = 0;
        for (int mm = 1; mm < mon; mm++)
            total += month_length(mm, leap);
        return total;
    endfunction

    // anonymous gregorian computus, then new year and five dates from easter
    function automatic void predict_dates(input logic [13:0] year_in);
        int                y, a, b, c, d, e, f, g, h, i, k, l, m, s;
        int                easter_mon, easter_dom, easter_ord, ord, mon;
        bit                leap;
        ehd_pkg::t_holiday hol;
        t_date_beat        beat;
        y    = int'(year_in);
        leap = (y % 100 == 0) ? (y % 400 == 0) : (y % 4 == 0);
        a = y % 19;
        b = y / 100;
        c = y % 100;
        d = b / 4;
        e = b % 4;
        f = (b + 8) / 25;
        g = (b - f + 1) / 3;
        h = (19 * a + b - d - g + 15) % 30;
        i = c / 4;
        k = c % 4;
        l = (32 + 2 * e + 2 * i - h - k) % 7;
        m = (a + 11 * h + 22 * l) / 451;
        s = h + l + 114 - 7 * m;
        easter_mon = s / 31;
        easter_dom = s % 31 + 1;
        if (easter_mon < 1 || easter_mon > 12)
            easter_mon = 3;
        easter_ord = days_before_month(easter_mon, leap) + easter_dom;
        for (int n = 0; n < HOLIDAYS_PER_YEAR; n++) begin
            hol = ehd_pkg::t_holiday'(n);
            case (hol)
                ehd_pkg::HOL_NEW_YEAR:  ord = int'(ehd_pkg::ORD_NEW_YEAR);
                ehd_pkg::HOL_CARNIVAL:  ord = easter_ord - int'(ehd_pkg::OFS_CARNIVAL);
                ehd_pkg::HOL_GOOD_FRI:  ord = easter_ord - int'(ehd_pkg::OFS_GOOD_FRI);
                ehd_pkg::HOL_ASCENSION: ord = easter_ord + int'(ehd_pkg::OFS_ASCENSION);
                ehd_pkg::HOL_WHITSUN:   ord = easter_ord + int'(ehd_pkg::OFS_WHITSUN);
                default:                ord = easter_ord;
            endcase
            mon = 1;
            for (int mm = 2; mm <= 12; mm++)
                if (days_before_month(mm, leap) < ord)
                    mon = mm;
            beat.hol  = hol;
            beat.mon  = 4'(mon);
            beat.dom  = 5'(ord - days_before_month(mon, leap));
            beat.ord  = 9'(ord);
            beat.last = (hol == ehd_pkg::HOL_WHITSUN);
            date_queue.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                predict_dates(i_year);
                years_seen++;
            end
            if (i_valid) begin
                beats_seen++;
                if (date_queue.size() == 0) begin
                    $error("result beat with no year pending: holiday %0d", i_holiday);
                    fail_count++;
                end else begin
                    want = date_queue.pop_front();
                    if (i_holiday !== want.hol) begin
                        $error("holiday: expected %0d, actual %0d", want.hol, i_holiday);
                        fail_count++;
                    end
                    if (i_month_number !== want.mon) begin
                        $error("month_number: expected %0d, actual %0d",
                               want.mon, i_month_number);
                        fail_count++;
                    end
                    if (i_day_of_month !== want.dom) begin
                        $error("day_of_month: expected %0d, actual %0d",
                               want.dom, i_day_of_month);
                        fail_count++;
                    end
                    if (i_ordinal_day !== want.ord) begin
                        $error("ordinal_day: expected %0d, actual %0d",
                               want.ord, i_ordinal_day);
                        fail_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_last);
                        fail_count++;
                    end
                end
            end
            pending_count = date_queue.size();
        end
    end

endmodule

FILE: tb/sv/easter_holiday_dates_tb.sv
// easter_holiday_dates_tb: drives years into the holiday date block in random bursts,
// directed edge years first, then random ones; checking lives in ehd_checker
// depends on ehd_pkg, easter_holiday_dates and ehd_checker
module easter_holiday_dates_tb;

    localparam int RANDOM_YEARS   = 160;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int DRAIN_CYCLES   = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [13:0] i_year;
    logic        o_valid;
    logic [2:0]  o_holiday;
    logic [3:0]  o_month_number;
    logic [4:0]  o_day_of_month;
    logic [8:0]  o_ordinal_day;
    logic        o_last;

    int          fail_count;
    int          pending;
    int          years_taken;
    int          beats_checked;
    int          idle_cycles = 0;
    logic [13:0] year_plan [$];

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    easter_holiday_dates i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_year         (i_year),
        .o_valid        (o_valid),
        .o_holiday      (o_holiday),
        .o_month_number (o_month_number),
        .o_day_of_month (o_day_of_month),
        .o_ordinal_day  (o_ordinal_day),
        .o_last         (o_last)
    );

    ehd_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_year         (i_year),
        .i_valid        (o_valid),
        .i_holiday      (o_holiday),
        .i_month_number (o_month_number),
        .i_day_of_month (o_day_of_month),
        .i_ordinal_day  (o_ordinal_day),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_years        (years_taken),
        .o_beats        (beats_checked)
    );

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // call at a rising edge; returns at the edge that takes the year
    task automatic send_year(input logic [13:0] year_val);
        start  <= 1'b1;
        i_year <= year_val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    initial begin
        int burst;
        int gap;
        int idx;
        start   = 1'b0;
        i_year  = '0;
        i_rst_n = 1'b0;

        // leap rules, easter extremes, late-full-moon correction, out-of-range years
        year_plan = '{14'd1583, 14'd9999, 14'd0, 14'd16383, 14'd1, 14'd2000, 14'd1900,
                      14'd2100, 14'd2400, 14'd2024, 14'd2019, 14'd1818, 14'd2285,
                      14'd1943, 14'd2038, 14'd1954, 14'd1981, 14'd4096, 14'd8192,
                      14'd10000, 14'd12000};
        for (int n = 0; n < RANDOM_YEARS; n++) begin
            if ($urandom_range(0, 3) == 0)
                year_plan.push_back(14'($urandom_range(0, 16383)));
            else
                year_plan.push_back(14'($urandom_range(1583, 9999)));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idx = 0;
        while (idx < year_plan.size()) begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && idx < year_plan.size(); j++) begin
                send_year(year_plan[idx]);
                idx++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("Summary: %0d years taken (%0d directed, rest random incl. out-of-range)",
                 years_taken, year_plan.size() - RANDOM_YEARS);
        $display("Summary: %0d holiday beats compared, %0d mismatches",
                 beats_checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
